// ===== design/euler_angles_to_axes_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euler angles to axes block
// Short forms for clocked assertions with an active-low reset that disables them.
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_AXES_MACROS_SVH
`define EULER_ANGLES_TO_AXES_MACROS_SVH

// Same-cycle implication.
`define EA2A_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EA2A_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ea2a_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler angles to axes package
// Formats, pipeline depths and arithmetic helpers shared by the lanes, the
// merge stage and the top level.
// ----------------------------------------------------------------------------
package ea2a_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int SINCOS_STEPS    = 16;

    localparam int IN_W      = 16;
    localparam int OUT_W     = OUT_FRAC_BITS + 2;
    localparam int WORK_FRAC = 30;
    localparam int ZFRAC     = 20;
    localparam int SC_W      = 32;
    localparam int ZW        = 29;
    localparam int PROD_W    = 2 * SC_W;
    localparam int SUM_W     = SC_W + 1;
    localparam int TO_W      = SUM_W + 1;
    localparam int NUM_AXES  = 9;

    // Angle constants in input units.
    localparam int FULL    = 360 << ANGLE_FRAC_BITS;
    localparam int HALF    = 180 << ANGLE_FRAC_BITS;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int ZSHIFT  = ZFRAC - ANGLE_FRAC_BITS;

    // Wrapping: bias the input to a positive value that is congruent to
    // angle plus half a turn, then strip multiples of a full turn.
    localparam int IN_SPAN    = 2 ** (IN_W - 1);
    localparam int WRAP_M     = (IN_SPAN + FULL - 1) / FULL;
    localparam int WRAP_BIAS  = HALF + FULL * WRAP_M;
    localparam int WRAP_MAX   = IN_SPAN - 1 + WRAP_BIAS;
    localparam int WRAP_STEPS = $clog2(WRAP_MAX / FULL + 1);
    localparam int WRAP_W     = $clog2((2 ** WRAP_STEPS) * FULL);
    localparam int A_W        = $clog2(HALF) + 2;

    // Pipeline depths.
    localparam int LANE_ST  = SINCOS_STEPS + 2;
    localparam int MERGE_ST = 3;
    localparam int PIPE_ST  = LANE_ST + MERGE_ST;

    // Result component positions.
    localparam int IDX_FWD_X = 0;
    localparam int IDX_FWD_Y = 1;
    localparam int IDX_FWD_Z = 2;
    localparam int IDX_RGT_X = 3;
    localparam int IDX_RGT_Y = 4;
    localparam int IDX_RGT_Z = 5;
    localparam int IDX_UP_X  = 6;
    localparam int IDX_UP_Y  = 7;
    localparam int IDX_UP_Z  = 8;

    typedef logic signed [SC_W-1:0]  sc_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [NUM_AXES-1:0][OUT_W-1:0] axes_t;

    typedef struct packed {
        logic [LANE_ST-1:0] en;
    } lane_ctrl_t;

    typedef struct packed {
        logic [MERGE_ST-1:0] en;
    } merge_ctrl_t;

    localparam sc_t CORDIC_GAIN = SC_W'(652032874);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (WORK_FRAC - 1);
    localparam int OUT_SH = WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [TO_W-1:0] OUT_HALF = TO_W'(1) << (OUT_SH - 1);
    localparam logic signed [TO_W-1:0] OUT_ONE  = TO_W'(1) << OUT_FRAC_BITS;

    // Arctangent of 2^-i in degrees with ZFRAC fraction bits.
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = ZW'(47185920);
            1:       r = ZW'(27855475);
            2:       r = ZW'(14718068);
            3:       r = ZW'(7471121);
            4:       r = ZW'(3750058);
            5:       r = ZW'(1876857);
            6:       r = ZW'(938658);
            7:       r = ZW'(469357);
            8:       r = ZW'(234682);
            9:       r = ZW'(117342);
            10:      r = ZW'(58671);
            11:      r = ZW'(29335);
            12:      r = ZW'(14668);
            13:      r = ZW'(7334);
            14:      r = ZW'(3667);
            15:      r = ZW'(1833);
            16:      r = ZW'(917);
            17:      r = ZW'(458);
            18:      r = ZW'(229);
            19:      r = ZW'(115);
            20:      r = ZW'(57);
            21:      r = ZW'(29);
            22:      r = ZW'(14);
            23:      r = ZW'(7);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Brings an angle into [-HALF, HALF) by conditional subtraction of
    // power-of-two multiples of a full turn.
    function automatic logic signed [A_W-1:0] wrap_angle(input logic signed [IN_W-1:0] a);
        logic [WRAP_W-1:0] v;
        v = WRAP_W'(int'(a) + WRAP_BIAS);
        for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
            if (v >= WRAP_W'(FULL << k)) begin
                v = v - WRAP_W'(FULL << k);
            end
        end
        return A_W'(int'(v) - HALF);
    endfunction

    // Product of two values with WORK_FRAC fraction bits, rounded.
    function automatic sc_t fmul(input sc_t a, input sc_t b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        return SC_W'((p + PROD_HALF) >>> WORK_FRAC);
    endfunction

    // Rounds to the output format and saturates to plus or minus one.
    function automatic logic [OUT_W-1:0] to_out(input sum_t v);
        logic signed [TO_W-1:0] t;
        t = (TO_W'(v) + OUT_HALF) >>> OUT_SH;
        if (t > OUT_ONE) begin
            t = OUT_ONE;
        end else if (t < -OUT_ONE) begin
            t = -OUT_ONE;
        end
        return OUT_W'(t);
    endfunction

endpackage

// ===== design/ea2a_lane.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine lane
// Wraps one angle to the right half plane and runs a fully pipelined CORDIC
// rotation, one step per stage.
// ----------------------------------------------------------------------------
module ea2a_lane
    import ea2a_pkg::*;
(
    input  logic                   clk,
    input  lane_ctrl_t             ctrl,
    input  logic signed [IN_W-1:0] angle,
    output sc_t                    sin_val,
    output sc_t                    cos_val
);

    logic signed [ZW-1:0]  z0_reg, z0_next;
    logic                  neg0_reg, neg0_next;
    logic signed [A_W-1:0] a_wrap;

    sc_t                   x_reg [SINCOS_STEPS];
    sc_t                   y_reg [SINCOS_STEPS];
    logic                  neg_reg [SINCOS_STEPS];
    logic signed [ZW-1:0]  z_reg [SINCOS_STEPS-1];

    sc_t                   sin_reg, sin_next;
    sc_t                   cos_reg, cos_next;

    // Wrap and fold into [-90, 90] degrees; a fold negates both results.
    always_comb
    begin
        logic signed [A_W-1:0] a_q;
        a_wrap    = wrap_angle(angle);
        neg0_next = 1'b0;
        a_q       = a_wrap;
        if (a_wrap > QUARTER) begin
            a_q       = A_W'(a_wrap - HALF);
            neg0_next = 1'b1;
        end else if (a_wrap < -QUARTER) begin
            a_q       = A_W'(a_wrap + HALF);
            neg0_next = 1'b1;
        end
        z0_next = ZW'(a_q) <<< ZSHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0]) begin
            z0_reg   <= z0_next;
            neg0_reg <= neg0_next;
        end
    end

    for (genvar i = 0; i < SINCOS_STEPS; i++) begin : g_step
        sc_t                  x_in, y_in, x_next, y_next;
        logic signed [ZW-1:0] z_in;
        logic                 neg_in;
        logic                 dir;

        if (i == 0) begin : g_first
            assign x_in   = CORDIC_GAIN;
            assign y_in   = '0;
            assign z_in   = z0_reg;
            assign neg_in = neg0_reg;
        end else begin : g_next
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        assign dir    = !z_in[ZW-1];
        assign x_next = dir ? x_in - (y_in >>> i) : x_in + (y_in >>> i);
        assign y_next = dir ? y_in + (x_in >>> i) : y_in - (x_in >>> i);

        always_ff @(posedge clk)
        begin
            if (ctrl.en[i+1]) begin
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                neg_reg[i] <= neg_in;
            end
        end

        // The residual angle of the last step is not needed.
        if (i < SINCOS_STEPS - 1) begin : g_z
            logic signed [ZW-1:0] z_next;
            assign z_next = dir ? z_in - atan_deg(i) : z_in + atan_deg(i);
            always_ff @(posedge clk)
            begin
                if (ctrl.en[i+1]) begin
                    z_reg[i] <= z_next;
                end
            end
        end
    end

    always_comb
    begin
        sin_next = neg_reg[SINCOS_STEPS-1] ? -y_reg[SINCOS_STEPS-1] : y_reg[SINCOS_STEPS-1];
        cos_next = neg_reg[SINCOS_STEPS-1] ? -x_reg[SINCOS_STEPS-1] : x_reg[SINCOS_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[LANE_ST-1]) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== design/ea2a_merge.sv =====
// ----------------------------------------------------------------------------
// Axis merge stage
// Combines the sines and cosines of the three lanes into the forward, right
// and up vectors over two product stages and one rounding stage.
// ----------------------------------------------------------------------------
module ea2a_merge
    import ea2a_pkg::*;
(
    input  logic        clk,
    input  merge_ctrl_t ctrl,
    input  sc_t         sp,
    input  sc_t         cp,
    input  sc_t         sy,
    input  sc_t         cy,
    input  sc_t         sr,
    input  sc_t         cr,
    output axes_t       axes
);

    // First product stage.
    sc_t  spcy_reg, spsy_reg, fx_reg, fy_reg, rz_reg, uz_reg;
    sc_t  sr1_reg, cr1_reg, sy1_reg, cy1_reg;
    sum_t fz_reg;

    // Second product stage.
    sc_t  pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg, pg_reg, ph_reg;
    sc_t  fx2_reg, fy2_reg, rz2_reg, uz2_reg;
    sum_t fz2_reg;

    axes_t axes_reg, axes_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0]) begin
            spcy_reg <= fmul(sp, cy);
            spsy_reg <= fmul(sp, sy);
            fx_reg   <= fmul(cp, cy);
            fy_reg   <= fmul(cp, sy);
            rz_reg   <= fmul(sr, cp);
            uz_reg   <= fmul(cr, cp);
            fz_reg   <= -SUM_W'(sp);
            sr1_reg  <= sr;
            cr1_reg  <= cr;
            sy1_reg  <= sy;
            cy1_reg  <= cy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1]) begin
            pa_reg  <= fmul(sr1_reg, spcy_reg);
            pb_reg  <= fmul(cr1_reg, sy1_reg);
            pc_reg  <= fmul(sr1_reg, spsy_reg);
            pd_reg  <= fmul(cr1_reg, cy1_reg);
            pe_reg  <= fmul(cr1_reg, spcy_reg);
            pf_reg  <= fmul(sr1_reg, sy1_reg);
            pg_reg  <= fmul(cr1_reg, spsy_reg);
            ph_reg  <= fmul(sr1_reg, cy1_reg);
            fx2_reg <= fx_reg;
            fy2_reg <= fy_reg;
            fz2_reg <= fz_reg;
            rz2_reg <= rz_reg;
            uz2_reg <= uz_reg;
        end
    end

    always_comb
    begin
        axes_next[IDX_FWD_X] = to_out(SUM_W'(fx2_reg));
        axes_next[IDX_FWD_Y] = to_out(SUM_W'(fy2_reg));
        axes_next[IDX_FWD_Z] = to_out(fz2_reg);
        axes_next[IDX_RGT_X] = to_out(SUM_W'(pa_reg) - SUM_W'(pb_reg));
        axes_next[IDX_RGT_Y] = to_out(SUM_W'(pc_reg) + SUM_W'(pd_reg));
        axes_next[IDX_RGT_Z] = to_out(SUM_W'(rz2_reg));
        axes_next[IDX_UP_X]  = to_out(SUM_W'(pe_reg) + SUM_W'(pf_reg));
        axes_next[IDX_UP_Y]  = to_out(SUM_W'(pg_reg) - SUM_W'(ph_reg));
        axes_next[IDX_UP_Z]  = to_out(SUM_W'(uz2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2]) begin
            axes_reg <= axes_next;
        end
    end

    assign axes = axes_reg;

endmodule

// ===== design/euler_angles_to_axes.sv =====
// ----------------------------------------------------------------------------
// Euler angles to axes
// Turns pitch, yaw and roll in degrees (signed, 6 fraction bits) into the
// forward, right and up vectors of the rotation, nine Q1.14 components
// saturated to plus or minus one.
// Input channel: in_valid, in_stall and the three angles. A request is taken
// at a clock edge where in_valid is high and in_stall is low. Output channel:
// out_valid, out_stall and the nine components, taken the same way.
// Throughput is one request per cycle while in_stall is low. The pipeline has
// one wrap stage, one stage per CORDIC step and one sign stage in each of three
// parallel lanes, then two product stages and one rounding stage; the CORDIC
// step count sets the depth.
// Each stage holds a valid bit and moves forward when the stage after it is
// empty or moving, so bubbles close up. A stalled result stays in the output
// register while earlier stages keep filling; in_stall rises only when every
// stage holds a request. Reset empties the pipeline; no result is pending.
// ----------------------------------------------------------------------------
`include "euler_angles_to_axes_macros.svh"

module euler_angles_to_axes
    import ea2a_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  pitch_deg,
    input  logic signed [IN_W-1:0]  yaw_deg,
    input  logic signed [IN_W-1:0]  roll_deg,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] forward_x,
    output logic signed [OUT_W-1:0] forward_y,
    output logic signed [OUT_W-1:0] forward_z,
    output logic signed [OUT_W-1:0] right_x,
    output logic signed [OUT_W-1:0] right_y,
    output logic signed [OUT_W-1:0] right_z,
    output logic signed [OUT_W-1:0] up_x,
    output logic signed [OUT_W-1:0] up_y,
    output logic signed [OUT_W-1:0] up_z
);

    logic [PIPE_ST-1:0] valid_reg, valid_next;
    logic [PIPE_ST-1:0] adv;
    lane_ctrl_t         lane_ctrl;
    merge_ctrl_t        merge_ctrl;
    sc_t                sp, cp, sy, cy, sr, cr;
    axes_t              axes;

    // Handshake events that the checks below look at.
    logic               in_take;
    logic               out_last;

    // A stage can load when it and every stage after it are not all full
    // behind a stalled output.
    always_comb
    begin
        for (int k = 0; k < PIPE_ST; k++) begin
            adv[k] = !(out_stall &&
                       ((valid_reg >> k) == ({PIPE_ST{1'b1}} >> k)));
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < PIPE_ST; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign lane_ctrl.en  = adv[LANE_ST-1:0];
    assign merge_ctrl.en = adv[PIPE_ST-1:LANE_ST];

    // One lane per angle, all advancing together.
    ea2a_lane u_lane_pitch (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .angle   (pitch_deg),
        .sin_val (sp),
        .cos_val (cp)
    );

    ea2a_lane u_lane_yaw (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .angle   (yaw_deg),
        .sin_val (sy),
        .cos_val (cy)
    );

    ea2a_lane u_lane_roll (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .angle   (roll_deg),
        .sin_val (sr),
        .cos_val (cr)
    );

    ea2a_merge u_merge (
        .clk  (clk),
        .ctrl (merge_ctrl),
        .sp   (sp),
        .cp   (cp),
        .sy   (sy),
        .cy   (cy),
        .sr   (sr),
        .cr   (cr),
        .axes (axes)
    );

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[PIPE_ST-1];

    assign forward_x = axes[IDX_FWD_X];
    assign forward_y = axes[IDX_FWD_Y];
    assign forward_z = axes[IDX_FWD_Z];
    assign right_x   = axes[IDX_RGT_X];
    assign right_y   = axes[IDX_RGT_Y];
    assign right_z   = axes[IDX_RGT_Z];
    assign up_x      = axes[IDX_UP_X];
    assign up_y      = axes[IDX_UP_Y];
    assign up_z      = axes[IDX_UP_Z];

    // A request is taken, or the last result in the pipeline is taken.
    assign in_take  = in_valid && !in_stall;
    assign out_last = out_valid && !out_stall && !valid_reg[PIPE_ST-2];

    // The input is held off only when the whole pipeline is occupied.
    `EA2A_ASSERT_IMP(a_stall_when_full, clk, rst_n, in_stall, &valid_reg, "stall with room left")

    // An accepted request occupies the first stage on the next cycle.
    `EA2A_ASSERT_NXT(a_accept_loads, clk, rst_n, in_take, valid_reg[0], "accepted request lost")

    // A stage that was not allowed to move still holds its request.
    `EA2A_ASSERT_NXT(a_hold_keeps, clk, rst_n, 1'b1, &($past(adv) | valid_reg), "request dropped")

    // A taken result with nothing behind it leaves the output empty.
    `EA2A_ASSERT_NXT(a_out_drain, clk, rst_n, out_last, !out_valid, "result repeated")

endmodule
